>>> rtl/ihg_pkg.sv
`timescale 1ns / 1ps

package ihg_pkg;

  localparam int SEED_W   = 64;
  localparam int SCALE_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 64;

  // xorshift64 shift amounts
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  // uniform term: top 24 bits of the state, centered by subtracting one half
  localparam int TERM_W    = 24;
  localparam int TERM_LSB  = SEED_W - TERM_W;
  localparam int TERM_BIAS = 1 << (TERM_W - 1);

  // S * scale / 2^25, round half up
  localparam int PROD_SHIFT = 25;
  localparam int ROUND_BIAS = 1 << (PROD_SHIFT - 1);

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam logic [SEED_W-1:0]  SEED_RESET  = '0;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

  // register select is paddr[3]: seed at 0x0, scale at 0x8
  localparam logic REG_SEED  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  function automatic logic [SEED_W-1:0] xorshift_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] t;
    t = s ^ (s << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

endpackage

>>> rtl/ihg_channels.sv
`timescale 1ns / 1ps

interface ihg_req_if;
  logic valid;
  logic ready;
  logic first;

  modport source (output valid, output first, input ready);
  modport sink (input valid, input first, output ready);
endinterface

interface ihg_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/ihg_gen.sv
`timescale 1ns / 1ps

module ihg_gen #(
  parameter int ROUNDS = 3,
  parameter int SUM_W  = 27
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_first,
  output logic                           in_ready,
  input  logic [ihg_pkg::SEED_W-1:0]     seed_inc,
  output logic                           sum_valid,
  output logic signed [SUM_W-1:0]        sum,
  input  logic                           sum_ready
);
  import ihg_pkg::*;

  logic [SEED_W-1:0]        gen;
  logic [SEED_W-1:0]        chain [ROUNDS+1];
  logic signed [SUM_W-1:0]  sum_next;
  logic                     accept;

  assign chain[0] = in_first ? seed_inc : gen;

  for (genvar k = 0; k < ROUNDS; k++) begin : g_step
    assign chain[k+1] = xorshift_step(chain[k]);
  end

  always_comb begin
    sum_next = '0;
    for (int k = 1; k <= ROUNDS; k++) begin
      sum_next = sum_next
               + $signed({{(SUM_W-TERM_W){1'b0}}, chain[k][SEED_W-1:TERM_LSB]})
               - SUM_W'(TERM_BIAS);
    end
  end

  assign in_ready = !sum_valid || sum_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen       <= SEED_W'(1);
      sum_valid <= 1'b0;
    end else begin
      if (accept) begin
        gen <= chain[ROUNDS];
      end
      if (in_ready) begin
        sum_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum <= sum_next;
    end
  end

endmodule

>>> rtl/ihg_scale.sv
`timescale 1ns / 1ps

module ihg_scale #(
  parameter int SUM_W = 27
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sum_valid,
  input  logic signed [SUM_W-1:0]           sum,
  output logic                              sum_ready,
  input  logic [ihg_pkg::SCALE_W-1:0]       scale,
  output logic                              out_valid,
  output logic signed [ihg_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                              out_ready
);
  import ihg_pkg::*;

  localparam int PROD_W = SUM_W + SCALE_W + 1;
  localparam int RES_W  = PROD_W + 1 - PROD_SHIFT;
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(SAMPLE_MAX);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(SAMPLE_MIN);

  logic                       prod_valid;
  logic                       prod_ready;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W:0]     rnd;
  logic signed [RES_W-1:0]    res;
  logic signed [SAMPLE_W-1:0] sample_next;

  assign prod_ready = !out_valid || out_ready;
  assign sum_ready  = !prod_valid || prod_ready;

  assign prod_next = $signed(sum) * $signed({1'b0, scale});

  // floor((p + 2^24) / 2^25), then clamp to Q2.13
  assign rnd = (PROD_W+1)'(prod) + (PROD_W+1)'(ROUND_BIAS);
  assign res = $signed(rnd[PROD_W:PROD_SHIFT]);

  always_comb begin
    priority if (res > RES_MAX) begin
      sample_next = SAMPLE_W'(SAMPLE_MAX);
    end else if (res < RES_MIN) begin
      sample_next = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sample_next = res[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (sum_ready) begin
        prod_valid <= sum_valid;
      end
      if (prod_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      prod <= prod_next;
    end
    if (prod_valid && prod_ready) begin
      out_sample <= sample_next;
    end
  end

endmodule

>>> rtl/irwin_hall_gaussian_generator.sv
`timescale 1ns / 1ps
// Approximately normal noise source: each request transaction on req yields
// one signed Q2.13 sample transaction on rsp. A 64-bit xorshift generator is
// stepped ROUNDS times per sample; the centered top 24 bits of each step are
// summed, scaled by the Q2.14 scale register, rounded and saturated.
//   req  : valid/ready, payload first (1 = reload generator to seed + 1).
//   rsp  : valid/ready, payload sample (signed 16-bit Q2.13).
//   APB  : seed at 0x0 (64 bits), scale at 0x8 (low 16 bits). pready is tied
//          high; writes land on the access cycle. Only paddr[3] is decoded.
// Pipeline: the sum register loads at the req edge, then the product
// register, then the output register, which presents the rsp sample.
// Throughput: one sample per cycle unless rsp stalls. The generator update
// runs all ROUNDS xorshift steps combinationally, setting the clock limit.
// Reset: generator = 1, seed = 0, scale = 1.0, pipeline empty.
// Stall: each stage holds its data while the next is full; a stalled rsp
// back-pressures req only once all three stages are occupied.
module irwin_hall_gaussian_generator #(
  parameter int ROUNDS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  ihg_req_if.sink                       req,
  ihg_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ihg_pkg::ADDR_W-1:0]    paddr,
  input  logic [ihg_pkg::DATA_W-1:0]    pwdata,
  output logic [ihg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ihg_pkg::*;

  // sum of ROUNDS terms, each in [-2^23, 2^23)
  localparam int SUM_W = TERM_W + 1 + $clog2(ROUNDS);

  logic [SEED_W-1:0]       seed;
  logic [SEED_W-1:0]       seed_inc;   // seed + 1, kept ready for reloads
  logic [SCALE_W-1:0]      scale;
  logic                    wr_en;

  logic                    sum_valid;
  logic                    sum_ready;
  logic signed [SUM_W-1:0] sum;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= SEED_RESET;
      seed_inc <= SEED_RESET + SEED_W'(1);
      scale    <= SCALE_RESET;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_SEED: begin
          seed     <= pwdata;
          seed_inc <= pwdata + SEED_W'(1);   // all ones wraps to a stuck zero
        end
        REG_SCALE: begin
          scale <= pwdata[SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_SEED:  prdata = seed;
      REG_SCALE: prdata = DATA_W'(scale);
      default:   prdata = '0;
    endcase
  end

  // ---- generator and term sum ----
  ihg_gen #(
    .ROUNDS (ROUNDS),
    .SUM_W  (SUM_W)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_first  (req.first),
    .in_ready  (req.ready),
    .seed_inc  (seed_inc),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_ready (sum_ready)
  );

  // ---- scaling, rounding, saturation ----
  ihg_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .sum_ready  (sum_ready),
    .scale      (scale),
    .out_valid  (rsp.valid),
    .out_sample (rsp.sample),
    .out_ready  (rsp.ready)
  );

  // ---- assertions ----
  // the sum stage only stalls when the output side is backed up
  a_sum_stall: assert property (@(posedge clk) disable iff (rst)
    !sum_ready |-> (rsp.valid && !rsp.ready))
    else $error("sum stage stalled without output back-pressure");

  // req is only refused when the sum stage is full and stalled
  a_req_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (sum_valid && !sum_ready))
    else $error("request refused with room in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!rsp.valid && !sum_valid))
    else $error("pipeline not empty after reset");

endmodule

>>> tb/sv/ihg_noise_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports, predicts every sample
// and compares it with what the block returns.
module ihg_noise_checker #(
  parameter int ROUNDS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  ihg_req_if                         req_mon,
  ihg_rsp_if                         rsp_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ihg_pkg::ADDR_W-1:0] paddr,
  input  logic [ihg_pkg::DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         pending
);
  import ihg_pkg::*;

  localparam logic [63:0] GEN_AFTER_RESET = 64'd1;

  logic [63:0]        seed_q;
  logic [15:0]        scale_q;
  logic [63:0]        gen_q;
  logic signed [15:0] samples_due[$];

  // one sample from generator state st; st_next is the state it leaves behind
  function automatic logic signed [15:0] gaussian_sample(
    input  logic [63:0] st,
    input  logic [15:0] scl,
    output logic [63:0] st_next
  );
    logic [63:0]        s;
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    logic signed [15:0] res;
    s   = st;
    acc = '0;
    for (int k = 0; k < ROUNDS; k++) begin
      s   = s ^ (s << 13);
      s   = s ^ (s >> 7);
      s   = s ^ (s << 17);
      acc = acc + $signed({40'd0, s[63:40]}) - 64'sd8388608;
    end
    prod = acc * $signed({48'd0, scl});
    rnd  = (prod + 64'sd16777216) >>> 25;   // round half up, floor shift
    if (rnd > SAMPLE_MAX) begin
      res = 16'sh7fff;
    end else if (rnd < SAMPLE_MIN) begin
      res = 16'sh8000;
    end else begin
      res = rnd[15:0];
    end
    st_next = s;
    return res;
  endfunction

  always @(posedge clk) begin : track
    logic [63:0]        start;
    logic [63:0]        nxt;
    logic signed [15:0] want;
    if (rst) begin
      seed_q     <= SEED_RESET;
      scale_q    <= SCALE_RESET;
      gen_q      <= GEN_AFTER_RESET;
      samples_due.delete();
      mismatches = 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == REG_SEED) begin
          seed_q <= pwdata;
        end else begin
          scale_q <= pwdata[15:0];
        end
      end
      // compare before predicting so a same-edge request never feeds this check
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (samples_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: sample %0d arrived with no request outstanding",
                     $realtime, rsp_mon.sample);
          end
          mismatches++;
        end else begin
          want = samples_due.pop_front();
          if (rsp_mon.sample !== want) begin
            if (mismatches < 10) begin
              $display("%0t: sample expected %0d, got %0d",
                       $realtime, want, rsp_mon.sample);
            end
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        start = (req_mon.first != 1'b0) ? seed_q + 64'd1 : gen_q;
        want  = gaussian_sample(start, scale_q, nxt);
        gen_q <= nxt;
        samples_due.push_back(want);
      end
      pending <= samples_due.size();
    end
  end

endmodule

>>> tb/sv/tb_irwin_hall_gaussian_generator.sv
`timescale 1ns / 1ps

// Top of the bench: clock, reset, request/response traffic and register
// programming. Prediction and comparison live in ihg_noise_checker.
module tb_irwin_hall_gaussian_generator;
  import ihg_pkg::*;

  localparam int NOISE_ROUNDS = 3;
  // the slowest run plus register phases stays far below this
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 8;     // pipeline is 3 deep, leave margin
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 50;

  // seed is 64 bits wide, so registers sit 8 bytes apart
  localparam logic [ADDR_W-1:0] SEED_ADDR  = {REG_SEED, 3'b000};
  localparam logic [ADDR_W-1:0] SCALE_ADDR = {REG_SCALE, 3'b000};

  localparam logic [63:0] SEED_ONES      = '1;
  localparam logic [63:0] SEED_WRAP_ONES = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [15:0] SCALE_UNITY    = 16'd16384;
  localparam logic [15:0] SCALE_TOP      = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int  mismatches;
  int  pending;
  int  cycles = 0;
  // per-phase switches: when clear, that side runs with no gaps at all
  logic req_idle = 1'b1;
  logic rsp_idle = 1'b1;

  ihg_req_if req ();
  ihg_rsp_if rsp ();

  irwin_hall_gaussian_generator #(
    .ROUNDS (NOISE_ROUNDS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ihg_noise_checker #(
    .ROUNDS (NOISE_ROUNDS)
  ) noise_chk (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req),
    .rsp_mon    (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // watchdog: also catches samples that never come back
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Every task below starts and ends in the time step of a rising edge.
  // Handshakes are judged at the falling edge before the edge that counts:
  // by then valid/ready have settled and cannot change until that edge.

  // One request transaction. The gap only drops valid when it is nonzero,
  // so back-to-back requests keep valid high without a glitch.
  task automatic push_request(input logic reload);
    int   gap;
    logic hit;
    gap = req_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      req.first <= 1'($urandom_range(0, 1));   // junk payload while idle
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.first <= reload;
    do begin
      @(negedge clk);
      hit = req.ready;
      @(posedge clk);
    end while (!hit);
  endtask

  // Stop requests and wait for the block to empty out.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);                    // pending reflects the last edge now
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle held until pready. The bus
  // stays selected afterwards so a following write can go straight to setup.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
    logic hit;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      hit = pready;
      @(posedge clk);
    end while (!hit);
  endtask

  // Program both registers with the block idle. Upper bits of the scale
  // word are random garbage; only the low 16 bits may take effect.
  task automatic program_regs(input logic [63:0] seed_val, input logic [15:0] scale_val);
    settle();
    write_reg(SEED_ADDR, seed_val);
    write_reg(SCALE_ADDR, {$urandom(), 16'($urandom_range(0, 65535)), scale_val});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Response side: a random stall before each transaction, ready held
  // until one goes through.
  initial begin : rsp_drain
    int   stall;
    logic hit;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rsp_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do begin
        @(negedge clk);
        hit = rsp.valid;
        @(posedge clk);
      end while (hit !== 1'b1);
    end
  end

  initial begin : stimulus
    logic [63:0] seed_val;
    logic [15:0] scale_val;
    req.valid <= 1'b0;
    req.first <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset state: generator 1, seed 0, unity scale; a reload lands on 1 too
    push_request(1'b0);
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b0);

    // all-ones seed wraps to a zero generator: every term is -1/2
    program_regs(SEED_ONES, SCALE_UNITY);
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b0);

    // same stuck state at full scale: negative saturation
    program_regs(SEED_ONES, SCALE_TOP);
    push_request(1'b1);
    push_request(1'b0);

    // zero scale: all samples zero
    program_regs(SEED_ONES, '0);
    push_request(1'b1);

    // seed + 1 is all ones
    program_regs(SEED_WRAP_ONES, SCALE_TOP);
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b0);

    // random seed at full scale: may saturate either way
    program_regs({$urandom(), $urandom()}, SCALE_TOP);
    push_request(1'b1);
    repeat (4) push_request(1'b0);

    // smallest nonzero scale
    program_regs({$urandom(), $urandom()}, 16'd1);
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b0);

    // --- random phases ---
    // each phase usually reloads from its seed first and then mostly runs the
    // generator forward, with an occasional reload in the middle
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       seed_val = SEED_ONES;
        1:       seed_val = '0;
        2:       seed_val = SEED_WRAP_ONES;
        default: seed_val = {$urandom(), $urandom()};
      endcase
      case ($urandom_range(0, 7))
        0:       scale_val = '0;
        1:       scale_val = SCALE_TOP;
        2:       scale_val = SCALE_UNITY;
        default: scale_val = 16'($urandom_range(0, 65535));
      endcase
      program_regs(seed_val, scale_val);
      // some phases run one side or both flat out
      req_idle = ($urandom_range(0, 3) != 0);
      rsp_idle = ($urandom_range(0, 3) != 0);
      push_request($urandom_range(0, 3) != 0);
      for (int i = 1; i < PHASE_ITEMS; i++) begin
        push_request($urandom_range(0, 15) == 0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
